// ----- rtl/ordered_list_append_remove_search_macros.svh -----
// Assertion helpers. Define ASSERT_OFF to compile them out.
`ifndef ORDERED_LIST_APPEND_REMOVE_SEARCH_MACROS_SVH
`define ORDERED_LIST_APPEND_REMOVE_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is low.
`define OLARS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("olars assertion failed");

// Next-cycle implication, disabled while reset is low.
`define OLARS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("olars assertion failed");

`else

`define OLARS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define OLARS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/olars_pkg.sv -----
package olars_pkg;

  localparam int DEPTH       = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int OP_W        = 2;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = ((OP_W + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ST_W + CNT_W + 7) / 8) * 8;

  typedef logic [VALUE_WIDTH-1:0] value_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_SEARCH = 2'd2
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic   append;
    logic   remove;
    value_t key;
  } cell_ctl_t;

endpackage

// ----- rtl/olars_cell.sv -----
module olars_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  olars_pkg::cell_ctl_t ctl,
  input  logic                prev_valid,   // left neighbor holds an entry
  input  logic                hit_in,       // match somewhere to the left
  input  olars_pkg::value_t   next_value,   // right neighbor's entry
  input  logic                next_valid,
  output logic                hit_out,
  output olars_pkg::value_t   value_out,
  output logic                valid_out
);
  import olars_pkg::*;

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;
  logic   is_tail;

  assign is_tail   = !valid_r && prev_valid;
  assign hit_out   = hit_in || (valid_r && (value_r == ctl.key));
  assign value_out = value_r;
  assign valid_out = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.append && is_tail) begin
      value_nxt = ctl.key;
      valid_nxt = 1'b1;
    end else if (ctl.remove && hit_out) begin
      // at or past the first match: pull from the right
      value_nxt = next_value;
      valid_nxt = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule

// ----- rtl/ordered_list_append_remove_search.sv -----
// Channel | Dir | Ports                    | Beat contents
// in_     | in  | in_tvalid/tready/tdata   | op, value
// out_    | out | out_tvalid/tready/tdata  | status, entry_count
//
// One item per cycle unless stalled: the cell chain compares, shifts and appends
// in the accepting cycle; the result appears in the output register on the next
// cycle. The first-match ripple through all DEPTH cells sets the clock period.
// Reset (rst_n low, synchronous) empties the list at once: valid bits and the
// count clear, no sweep. in_tready drops only while a result sits untaken.
module ordered_list_append_remove_search (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [olars_pkg::IN_TDATA_W-1:0]  in_tdata,   // [1:0] op, [33:2] value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [olars_pkg::OUT_TDATA_W-1:0] out_tdata   // [1:0] status, [6:2] entry_count
);
  import olars_pkg::*;

  `include "ordered_list_append_remove_search_macros.svh"

  logic                   acc;
  logic [OP_W-1:0]        op;
  cell_ctl_t              ctl;
  logic                   full, empty, found;

  logic [DEPTH-1:0]       valid_vec;
  logic [DEPTH-1:0]       hit_vec;
  value_t                 value_vec [DEPTH];

  count_t                 held_count_r, count_nxt;
  status_t                status_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;

  // Skid-free output register: accept whenever the slot frees this cycle.
  assign in_tready  = !out_valid_r || out_tready;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  assign op         = in_tdata[OP_W-1:0];
  assign ctl.key    = in_tdata[OP_W +: VALUE_WIDTH];
  assign ctl.append = acc && (op == OP_APPEND);
  assign ctl.remove = acc && (op == OP_REMOVE);

  assign full  = (held_count_r == CNT_W'(DEPTH));
  assign empty = (held_count_r == '0);
  assign found = hit_vec[DEPTH-1];

  // Cell 0 sees a valid left edge so an empty list appends into it.
  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic   prev_v, hin, nxt_v;
      value_t nxt_val;
      if (g == 0) begin : g_first
        assign prev_v = 1'b1;
        assign hin    = 1'b0;
      end else begin : g_mid
        assign prev_v = valid_vec[g-1];
        assign hin    = hit_vec[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign nxt_val = '0;
        assign nxt_v   = 1'b0;
      end else begin : g_inner
        assign nxt_val = value_vec[g+1];
        assign nxt_v   = valid_vec[g+1];
      end
      olars_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .prev_valid (prev_v),
        .hit_in     (hin),
        .next_value (nxt_val),
        .next_valid (nxt_v),
        .hit_out    (hit_vec[g]),
        .value_out  (value_vec[g]),
        .valid_out  (valid_vec[g])
      );
    end
  endgenerate

  always_comb begin
    status_nxt = ST_OK;
    count_nxt  = held_count_r;
    unique case (op)
      OP_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          count_nxt = held_count_r + count_t'(1);
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (found) begin
          count_nxt = held_count_r - count_t'(1);
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_SEARCH: begin
        status_nxt = found ? ST_OK : ST_NOT_FOUND;
      end
      default: begin
        // unused code: no change, report OK
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (acc) begin
        held_count_r <= count_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_tdata_r <= OUT_TDATA_W'({count_nxt, status_nxt});
    end
  end

  // count stays in range, agrees with the valid bits, and tracks appends and removes
  `OLARS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, held_count_r <= CNT_W'(DEPTH))
  `OLARS_ASSERT_NOW(a_count_valid, clk, rst_n, 1'b1,
                    $countones(valid_vec) == 32'(held_count_r))
  `OLARS_ASSERT_NEXT(a_append_grows, clk, rst_n, ctl.append && !full,
                     held_count_r == $past(held_count_r) + count_t'(1))
  `OLARS_ASSERT_NEXT(a_remove_shrinks, clk, rst_n, ctl.remove && found,
                     held_count_r == $past(held_count_r) - count_t'(1))

endmodule
